[sv/can_rx_filter_fifo_macros.svh]
// ----------------------------------------------------------------------------
// can_rx_filter_fifo_macros.svh
// Assertion macros shared by the receive filter FIFO.
// ----------------------------------------------------------------------------
`ifndef CAN_RX_FILTER_FIFO_MACROS_SVH
`define CAN_RX_FILTER_FIFO_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("can_rx_filter_fifo: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("can_rx_filter_fifo: next-cycle check failed");

`endif

[sv/crf_pkg.sv]
// ----------------------------------------------------------------------------
// crf_pkg
// Types and constants of the CAN receive filter FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package crf_pkg;

	localparam int ID_W   = 29;
	localparam int DATA_W = 64;
	localparam int CFG_IDX_W = 2;

	// Request opcodes; the fourth code is ignored.
	typedef enum logic [1:0] {
		OP_FRAME = 2'd0,
		OP_READ  = 2'd1,
		OP_FLUSH = 2'd2
	} op_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CODE = 2'd1;

	// Commands from the request decoder to the frame buffer.
	typedef struct packed {
		logic push;
		logic pop;
		logic flush;
	} buf_cmd_t;

endpackage

`default_nettype wire

[sv/can_rx_filter_fifo.sv]
// ----------------------------------------------------------------------------
// can_rx_filter_fifo
// CAN receive buffer behind a mask/code acceptance filter.
//
//   channel  direction  handshake           payload
//   in       sink       in_valid/in_stall   opcode, frame_identifier, frame_data
//   out      source     out_valid/out_stall got_message, out_identifier, out_data
//   cfg      sink       cfg_valid/cfg_ready cfg_index, cfg_data
//
// A frame or flush is done at its accept edge.
// A read fetches the head from the memory port and shows it the next cycle.
// Requests stall only while a read result waits and out_stall is high.
// Reset clears pointers, fill count and filter; the memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module can_rx_filter_fifo
	import crf_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           opcode,
	input  wire logic [ID_W-1:0]      frame_identifier,
	input  wire logic [DATA_W-1:0]    frame_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      got_message,
	output logic [ID_W-1:0]           out_identifier,
	output logic [DATA_W-1:0]         out_data,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ID_W-1:0]      cfg_data
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [ID_W-1:0]   mask_q;
	logic [ID_W-1:0]   code_q;
	logic              in_acc;
	logic              id_pass;
	buf_cmd_t          cmd;
	logic [ID_W-1:0]   rd_id;
	logic [DATA_W-1:0] rd_data;
	logic              empty;
	logic [CNT_W-1:0]  count;
	logic              valid_s1;
	logic              got_s1;

	// Filter registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			code_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_MASK: mask_q <= cfg_data;
				REG_CODE: code_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Decode the request
	assign in_acc  = in_valid && !in_stall;
	assign id_pass = (((frame_identifier ^ code_q) & mask_q) == '0);

	always_comb begin
		cmd.push  = in_acc && (opcode == OP_FRAME) && id_pass;
		cmd.pop   = in_acc && (opcode == OP_READ);
		cmd.flush = in_acc && (opcode == OP_FLUSH);
	end

	crf_buffer #(
		.DEPTH (DEPTH)
	) u_buffer (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.wr_id   (frame_identifier),
		.wr_data (frame_data),
		.rd_id   (rd_id),
		.rd_data (rd_data),
		.empty   (empty),
		.count   (count)
	);

	// Result stage: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			got_s1   <= 1'b0;
		end else if (cmd.pop) begin
			valid_s1 <= 1'b1;
			got_s1   <= !empty;
		end else if (!out_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	assign in_stall       = valid_s1 && out_stall;
	assign out_valid      = valid_s1;
	assign got_message    = got_s1;
	assign out_identifier = got_s1 ? rd_id : '0;
	assign out_data       = got_s1 ? rd_data : '0;

	`include "can_rx_filter_fifo_macros.svh"

	`CRF_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count <= FULL_CNT)
	`CRF_ASSERT_NEXT(a_empty_read, clk, arst_n, cmd.pop && empty, out_valid && !got_message)
	`CRF_ASSERT_NEXT(a_flush_clears, clk, arst_n, cmd.flush, empty)
	`CRF_ASSERT_NEXT(a_push_grows, clk, arst_n, cmd.push && (count != FULL_CNT), count == $past(count) + 1'b1)

endmodule

`default_nettype wire

[sv/crf_buffer.sv]
// ----------------------------------------------------------------------------
// crf_buffer
// Frame storage in one synchronous memory with read and write pointers.
// A push into a full buffer drops the oldest frame.
// ----------------------------------------------------------------------------
`default_nettype none

module crf_buffer
	import crf_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int PTR_W = $clog2(DEPTH),
	parameter int CNT_W = $clog2(DEPTH + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire buf_cmd_t          cmd,
	input  wire logic [ID_W-1:0]   wr_id,
	input  wire logic [DATA_W-1:0] wr_data,
	output logic [ID_W-1:0]        rd_id,
	output logic [DATA_W-1:0]      rd_data,
	output logic                   empty,
	output logic [CNT_W-1:0]       count
);

	localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

	logic [ID_W+DATA_W-1:0] mem [DEPTH];
	logic [PTR_W-1:0]       rptr_q;
	logic [PTR_W-1:0]       wptr_q;
	logic [CNT_W-1:0]       count_q;
	logic [ID_W+DATA_W-1:0] rdata_q;
	logic                   full;
	logic [PTR_W-1:0]       rptr_inc;
	logic [PTR_W-1:0]       wptr_inc;

	assign full     = (count_q == FULL_CNT);
	assign empty    = (count_q == '0);
	assign count    = count_q;
	assign rptr_inc = (rptr_q == LAST_SLOT) ? '0 : rptr_q + 1'b1;
	assign wptr_inc = (wptr_q == LAST_SLOT) ? '0 : wptr_q + 1'b1;

	// Write the frame at the tail
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wptr_q] <= {wr_id, wr_data};
		end
	end

	// Read the head on a pop; hold otherwise so a stalled result stays put
	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			rdata_q <= mem[rptr_q];
		end
	end

	assign rd_id   = rdata_q[ID_W+DATA_W-1:DATA_W];
	assign rd_data = rdata_q[DATA_W-1:0];

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rptr_q  <= '0;
			wptr_q  <= '0;
			count_q <= '0;
		end else if (cmd.flush) begin
			rptr_q  <= '0;
			wptr_q  <= '0;
			count_q <= '0;
		end else if (cmd.push) begin
			wptr_q <= wptr_inc;
			if (full) begin
				rptr_q <= rptr_inc;
			end else begin
				count_q <= count_q + 1'b1;
			end
		end else if (cmd.pop && !empty) begin
			rptr_q  <= rptr_inc;
			count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire
